[rtl/bb3_pkg.sv]
`timescale 1ns / 1ps
// bb3_pkg: shared types and constants of the 3x3 box blur stream
// no dependencies; used by bb3_cfg, bb3_ctl, bb3_window, bb3_div, the top and the bench

package bb3_pkg;

	localparam int unsigned CH_W     = 8;
	localparam int unsigned SUM_W    = 12;
	localparam int unsigned MUL_W    = 14;
	localparam int unsigned DIV_SHIFT = 15;
	localparam int unsigned CFG_W    = 12;
	localparam int unsigned APB_AW   = 3;
	localparam int unsigned APB_DW   = 32;

	localparam logic [CFG_W-1:0] RST_WIDTH  = 12'd640;
	localparam logic [CFG_W-1:0] RST_HEIGHT = 12'd480;

	// reciprocal multipliers, scaled by 2**DIV_SHIFT
	localparam logic [MUL_W-1:0] MUL_DIV4 = 14'd8192;
	localparam logic [MUL_W-1:0] MUL_DIV6 = 14'd5462;
	localparam logic [MUL_W-1:0] MUL_DIV9 = 14'd3641;

	typedef enum logic {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		DIV4 = 2'd0,
		DIV6 = 2'd1,
		DIV9 = 2'd2
	} div_sel_t;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} rgb_t;

	// per word control handed from the counters to the window stage
	typedef struct packed {
		logic wr;
		logic emit;
		logic use_new;
		logic col0_en;
		logic row0_en;
		logic row2_en;
		logic frame_end;
	} ctl_t;

	function automatic logic [MUL_W-1:0] div_mul(input div_sel_t sel);
		logic [MUL_W-1:0] m;
		case (sel)
			DIV4: m = MUL_DIV4;
			DIV6: m = MUL_DIV6;
			DIV9: m = MUL_DIV9;
			default: m = MUL_DIV4;
		endcase
		return m;
	endfunction

	function automatic logic [2:0] div_half(input div_sel_t sel);
		logic [2:0] h;
		case (sel)
			DIV4: h = 3'd2;
			DIV6: h = 3'd3;
			DIV9: h = 3'd4;
			default: h = 3'd2;
		endcase
		return h;
	endfunction

endpackage

[rtl/bb3_stream_if.sv]
`timescale 1ns / 1ps
// bb3_in_if, bb3_out_if: valid/ready channels of the box blur stream
// depends on nothing

interface bb3_in_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] in_red;
	logic [7:0] in_green;
	logic [7:0] in_blue;

	modport source (output valid, action, in_red, in_green, in_blue, input ready);
	modport sink (input valid, action, in_red, in_green, in_blue, output ready);
endinterface

interface bb3_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;
	logic       frame_end;

	modport source (output valid, out_red, out_green, out_blue, frame_end, input ready);
	modport sink (input valid, out_red, out_green, out_blue, frame_end, output ready);
endinterface

[rtl/bb3_ram.sv]
`timescale 1ns / 1ps
// bb3_ram: generic simple dual port ram, one write and one registered read
// no dependencies

module bb3_ram #(
	parameter int unsigned WIDTH = 24,
	parameter int unsigned DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/bb3_cfg.sv]
`timescale 1ns / 1ps
// bb3_cfg: apb register file for frame width and height, with clamping
// depends on bb3_pkg

module bb3_cfg #(
	parameter int unsigned MAX_WIDTH  = 2048,
	parameter int unsigned MAX_HEIGHT = 2048
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [bb3_pkg::APB_AW-1:0]          paddr,
	input  logic [bb3_pkg::APB_DW-1:0]          pwdata,
	output logic [bb3_pkg::APB_DW-1:0]          prdata,
	output logic                                pready,
	output logic                                restart,
	output logic [$clog2(MAX_WIDTH+1)-1:0]      eff_w,
	output logic [$clog2(MAX_HEIGHT+2)-1:0]     eff_h
);

	localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
	localparam int unsigned HW = $clog2(MAX_HEIGHT + 2);

	logic [bb3_pkg::CFG_W-1:0] width_q;
	logic [bb3_pkg::CFG_W-1:0] height_q;
	logic                      wr_en;
	bb3_pkg::reg_idx_t         idx;

	assign pready  = 1'b1;
	assign idx     = bb3_pkg::reg_idx_t'(paddr[2]);
	assign wr_en   = psel && penable && pwrite;
	assign restart = wr_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= bb3_pkg::RST_WIDTH;
			height_q <= bb3_pkg::RST_HEIGHT;
		end else if (wr_en) begin
			case (idx)
				bb3_pkg::REG_WIDTH:  width_q  <= pwdata[bb3_pkg::CFG_W-1:0];
				bb3_pkg::REG_HEIGHT: height_q <= pwdata[bb3_pkg::CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			bb3_pkg::REG_WIDTH:  prdata = bb3_pkg::APB_DW'(width_q);
			bb3_pkg::REG_HEIGHT: prdata = bb3_pkg::APB_DW'(height_q);
			default:             prdata = '0;
		endcase
	end

	always_comb begin
		if (width_q < 12'd2) begin
			eff_w = WW'(2);
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			eff_w = WW'(MAX_WIDTH);
		end else begin
			eff_w = WW'(width_q);
		end
		if (height_q < 12'd2) begin
			eff_h = HW'(2);
		end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
			eff_h = HW'(MAX_HEIGHT);
		end else begin
			eff_h = HW'(height_q);
		end
	end

endmodule

[rtl/bb3_ctl.sv]
`timescale 1ns / 1ps
// bb3_ctl: input and output position counters, per word decode, first stage register
// depends on bb3_pkg

module bb3_ctl #(
	parameter int unsigned MAX_WIDTH  = 2048,
	parameter int unsigned MAX_HEIGHT = 2048
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                restart,
	input  logic [$clog2(MAX_WIDTH+1)-1:0]      eff_w,
	input  logic [$clog2(MAX_HEIGHT+2)-1:0]     eff_h,
	input  logic                                fire,
	input  logic                                action,
	input  bb3_pkg::rgb_t                       px,
	input  logic                                adv1,
	output logic                                ren,
	output logic [$clog2(MAX_WIDTH)-1:0]        raddr,
	output logic                                v_s1,
	output bb3_pkg::ctl_t                       ctl_s1,
	output bb3_pkg::rgb_t                       px_s1,
	output logic [$clog2(MAX_WIDTH)-1:0]        addr_s1
);

	localparam int unsigned CW = $clog2(MAX_WIDTH);
	localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
	localparam int unsigned RW = $clog2(MAX_HEIGHT + 2);
	localparam int unsigned OW = $clog2(MAX_HEIGHT);

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] ocol_q;
	logic [OW-1:0] orow_q;

	logic          drop;
	logic          drain;
	logic          take;
	logic          col_wrap;
	logic          ocol_last;
	logic [RW-1:0] orow_inc;
	bb3_pkg::ctl_t ctl;

	always_comb begin
		drain     = action || (row_q >= eff_h);
		drop      = action && (row_q < eff_h);
		take      = fire && !drop;
		col_wrap  = (WW'(col_q) + WW'(1)) >= eff_w;
		ocol_last = (WW'(ocol_q) + WW'(1)) == eff_w;
		orow_inc  = RW'(orow_q) + RW'(1);

		ctl.wr        = !drain;
		ctl.emit      = (row_q >= RW'(2)) || ((row_q == RW'(1)) && (col_q != '0));
		ctl.use_new   = col_q != '0;
		ctl.col0_en   = (col_q != '0) && (col_q != CW'(1));
		ctl.row0_en   = orow_q != '0;
		ctl.row2_en   = orow_inc < eff_h;
		ctl.frame_end = (orow_inc == eff_h) && ocol_last;
	end

	assign ren   = take;
	assign raddr = col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			ocol_q <= '0;
			orow_q <= '0;
		end else if (restart) begin
			col_q  <= '0;
			row_q  <= '0;
			ocol_q <= '0;
			orow_q <= '0;
		end else if (take) begin
			if (ctl.emit && ctl.frame_end) begin
				col_q  <= '0;
				row_q  <= '0;
				ocol_q <= '0;
				orow_q <= '0;
			end else begin
				if (ctl.emit) begin
					if (ocol_last) begin
						ocol_q <= '0;
						orow_q <= orow_q + OW'(1);
					end else begin
						ocol_q <= ocol_q + CW'(1);
					end
				end
				if (col_wrap) begin
					col_q <= '0;
					row_q <= row_q + RW'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take) begin
			v_s1 <= 1'b1;
		end else if (adv1) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ctl_s1  <= ctl;
			px_s1   <= drain ? '0 : px;
			addr_s1 <= col_q;
		end
	end

endmodule

[rtl/bb3_window.sv]
`timescale 1ns / 1ps
// bb3_window: 3x3 window shift registers and masked per channel sums
// depends on bb3_pkg

module bb3_window (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv1,
	input  bb3_pkg::ctl_t                ctl_s1,
	input  bb3_pkg::rgb_t                px_s1,
	input  bb3_pkg::rgb_t                top_rd,
	input  bb3_pkg::rgb_t                mid_rd,
	input  logic                         adv2,
	output logic                         v_s2,
	output logic [bb3_pkg::SUM_W-1:0]    sum_red_s2,
	output logic [bb3_pkg::SUM_W-1:0]    sum_green_s2,
	output logic [bb3_pkg::SUM_W-1:0]    sum_blue_s2,
	output bb3_pkg::div_sel_t            sel_s2,
	output logic                         frame_end_s2
);

	bb3_pkg::rgb_t win_q [3][3];
	bb3_pkg::rgb_t pick [3][3];
	bb3_pkg::rgb_t newcol [3];
	logic [2:0]    row_en;
	logic [2:0]    col_en;
	logic [bb3_pkg::SUM_W-1:0] sum_r;
	logic [bb3_pkg::SUM_W-1:0] sum_g;
	logic [bb3_pkg::SUM_W-1:0] sum_b;
	logic          load_s2;
	bb3_pkg::div_sel_t sel;

	assign newcol[0] = top_rd;
	assign newcol[1] = mid_rd;
	assign newcol[2] = px_s1;
	assign row_en    = {ctl_s1.row2_en, 1'b1, ctl_s1.row0_en};
	assign col_en    = {1'b1, 1'b1, ctl_s1.col0_en};
	assign load_s2   = adv1 && ctl_s1.emit;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			if (ctl_s1.use_new) begin
				pick[r][0] = win_q[r][1];
				pick[r][1] = win_q[r][2];
				pick[r][2] = newcol[r];
			end else begin
				pick[r][0] = win_q[r][0];
				pick[r][1] = win_q[r][1];
				pick[r][2] = win_q[r][2];
			end
		end
	end

	always_comb begin
		sum_r = '0;
		sum_g = '0;
		sum_b = '0;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				if (row_en[r] && col_en[c]) begin
					sum_r = sum_r + bb3_pkg::SUM_W'(pick[r][c].red);
					sum_g = sum_g + bb3_pkg::SUM_W'(pick[r][c].green);
					sum_b = sum_b + bb3_pkg::SUM_W'(pick[r][c].blue);
				end
			end
		end
	end

	always_comb begin
		if (ctl_s1.col0_en && ctl_s1.row0_en && ctl_s1.row2_en) begin
			sel = bb3_pkg::DIV9;
		end else if (!ctl_s1.col0_en && !(ctl_s1.row0_en && ctl_s1.row2_en)) begin
			sel = bb3_pkg::DIV4;
		end else begin
			sel = bb3_pkg::DIV6;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					win_q[r][c] <= '0;
				end
			end
		end else if (adv1) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
				win_q[r][2] <= newcol[r];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (load_s2) begin
			v_s2 <= 1'b1;
		end else if (adv2) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			sum_red_s2   <= sum_r;
			sum_green_s2 <= sum_g;
			sum_blue_s2  <= sum_b;
			sel_s2       <= sel;
			frame_end_s2 <= ctl_s1.frame_end;
		end
	end

endmodule

[rtl/bb3_div.sv]
`timescale 1ns / 1ps
// bb3_div: rounded division by 4, 6 or 9 via reciprocal multiply, output register
// depends on bb3_pkg and bb3_out_if

module bb3_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         v_s2,
	input  logic [bb3_pkg::SUM_W-1:0]    sum_red_s2,
	input  logic [bb3_pkg::SUM_W-1:0]    sum_green_s2,
	input  logic [bb3_pkg::SUM_W-1:0]    sum_blue_s2,
	input  bb3_pkg::div_sel_t            sel_s2,
	input  logic                         frame_end_s2,
	output logic                         adv2,
	output logic                         ready2,
	bb3_out_if.source                    result
);

	localparam int unsigned PW = bb3_pkg::SUM_W + bb3_pkg::MUL_W;

	logic                          out_v_q;
	logic                          out_free;
	logic [bb3_pkg::MUL_W-1:0]     mul;
	logic [bb3_pkg::SUM_W-1:0]     half;
	logic [PW-1:0]                 prod_r;
	logic [PW-1:0]                 prod_g;
	logic [PW-1:0]                 prod_b;
	bb3_pkg::rgb_t                 pix_q;
	logic                          frame_end_q;

	assign out_free = !out_v_q || result.ready;
	assign adv2     = v_s2 && out_free;
	assign ready2   = !v_s2 || out_free;

	always_comb begin
		mul    = bb3_pkg::div_mul(sel_s2);
		half   = bb3_pkg::SUM_W'(bb3_pkg::div_half(sel_s2));
		prod_r = PW'(sum_red_s2 + half) * PW'(mul);
		prod_g = PW'(sum_green_s2 + half) * PW'(mul);
		prod_b = PW'(sum_blue_s2 + half) * PW'(mul);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv2) begin
			out_v_q <= 1'b1;
		end else if (result.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			pix_q.red   <= prod_r[bb3_pkg::DIV_SHIFT +: bb3_pkg::CH_W];
			pix_q.green <= prod_g[bb3_pkg::DIV_SHIFT +: bb3_pkg::CH_W];
			pix_q.blue  <= prod_b[bb3_pkg::DIV_SHIFT +: bb3_pkg::CH_W];
			frame_end_q <= frame_end_s2;
		end
	end

	assign result.valid     = out_v_q;
	assign result.out_red   = pix_q.red;
	assign result.out_green = pix_q.green;
	assign result.out_blue  = pix_q.blue;
	assign result.frame_end = frame_end_q;

endmodule

[rtl/box_blur_3x3_stream_top.sv]
`timescale 1ns / 1ps
// box_blur_3x3_stream_top: 3x3 box blur over an rgb raster stream
// depends on bb3_pkg, bb3_in_if, bb3_out_if, bb3_ram, bb3_cfg, bb3_ctl, bb3_window, bb3_div
//
// pixel: valid/ready words in raster order; action 0 carries a pixel, action 1 is a
// drain word. result: one blurred word per output position, frame_end on the last.
// the output for position n appears once input word n + width + 1 is taken, so the
// last width + 1 outputs of a frame need drain words (or extra pixels, dropped).
// a drain word before the frame's pixels are all in is taken and gives nothing.
// throughput is one word per clock while result.ready holds; a word's result passes the
// line store read, then window sum, then reciprocal divide registers before it shows.
// two line stores of MAX_WIDTH x 24 bit hold the previous rows; no clearing pass.
// apb: register 0 at address 0 is frame width, register 1 at address 4 is frame height;
// a write restarts the frame; the user must make it only with the stream idle, the block
// does not check. reset clears the counters, the window and the pipeline valid flags,
// and sets 640 x 480. when result.ready is low the output word holds; the pipeline keeps
// filling and pixel.ready drops only once every stage holds a word.

module box_blur_3x3_stream_top #(
	parameter int unsigned MAX_WIDTH  = 2048,
	parameter int unsigned MAX_HEIGHT = 2048
) (
	input  logic                        clk,
	input  logic                        arst_n,
	bb3_in_if.sink                      pixel,
	bb3_out_if.source                   result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bb3_pkg::APB_AW-1:0]  paddr,
	input  logic [bb3_pkg::APB_DW-1:0]  pwdata,
	output logic [bb3_pkg::APB_DW-1:0]  prdata,
	output logic                        pready
);

	localparam int unsigned CW = $clog2(MAX_WIDTH);
	localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
	localparam int unsigned HW = $clog2(MAX_HEIGHT + 2);

	logic                      restart;
	logic [WW-1:0]             eff_w;
	logic [HW-1:0]             eff_h;
	logic                      fire;
	logic                      ren;
	logic [CW-1:0]             raddr;
	logic                      v_s1;
	bb3_pkg::ctl_t             ctl_s1;
	bb3_pkg::rgb_t             px_s1;
	bb3_pkg::rgb_t             px_in;
	logic [CW-1:0]             addr_s1;
	logic                      adv1;
	logic                      adv2;
	logic                      ready2;
	logic                      we;
	bb3_pkg::rgb_t             top_rd;
	bb3_pkg::rgb_t             mid_rd;
	logic                      v_s2;
	logic [bb3_pkg::SUM_W-1:0] sum_red_s2;
	logic [bb3_pkg::SUM_W-1:0] sum_green_s2;
	logic [bb3_pkg::SUM_W-1:0] sum_blue_s2;
	bb3_pkg::div_sel_t         sel_s2;
	logic                      frame_end_s2;

	assign pixel.ready = !v_s1 || !ctl_s1.emit || ready2;
	assign fire        = pixel.valid && pixel.ready;
	assign adv1        = v_s1 && (!ctl_s1.emit || ready2);
	assign we          = v_s1 && ctl_s1.wr;
	assign px_in.red   = pixel.in_red;
	assign px_in.green = pixel.in_green;
	assign px_in.blue  = pixel.in_blue;

	bb3_cfg #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.restart (restart),
		.eff_w   (eff_w),
		.eff_h   (eff_h)
	);

	bb3_ctl #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_ctl (
		.clk     (clk),
		.arst_n  (arst_n),
		.restart (restart),
		.eff_w   (eff_w),
		.eff_h   (eff_h),
		.fire    (fire),
		.action  (pixel.action),
		.px      (px_in),
		.adv1    (adv1),
		.ren     (ren),
		.raddr   (raddr),
		.v_s1    (v_s1),
		.ctl_s1  (ctl_s1),
		.px_s1   (px_s1),
		.addr_s1 (addr_s1)
	);

	// top row store takes what the middle store held, middle takes the new pixel
	bb3_ram #(
		.WIDTH ($bits(bb3_pkg::rgb_t)),
		.DEPTH (MAX_WIDTH)
	) u_top_line (
		.clk   (clk),
		.we    (we),
		.waddr (addr_s1),
		.wdata (mid_rd),
		.re    (ren),
		.raddr (raddr),
		.rdata (top_rd)
	);

	bb3_ram #(
		.WIDTH ($bits(bb3_pkg::rgb_t)),
		.DEPTH (MAX_WIDTH)
	) u_mid_line (
		.clk   (clk),
		.we    (we),
		.waddr (addr_s1),
		.wdata (px_s1),
		.re    (ren),
		.raddr (raddr),
		.rdata (mid_rd)
	);

	bb3_window u_window (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv1         (adv1),
		.ctl_s1       (ctl_s1),
		.px_s1        (px_s1),
		.top_rd       (top_rd),
		.mid_rd       (mid_rd),
		.adv2         (adv2),
		.v_s2         (v_s2),
		.sum_red_s2   (sum_red_s2),
		.sum_green_s2 (sum_green_s2),
		.sum_blue_s2  (sum_blue_s2),
		.sel_s2       (sel_s2),
		.frame_end_s2 (frame_end_s2)
	);

	bb3_div u_div (
		.clk          (clk),
		.arst_n       (arst_n),
		.v_s2         (v_s2),
		.sum_red_s2   (sum_red_s2),
		.sum_green_s2 (sum_green_s2),
		.sum_blue_s2  (sum_blue_s2),
		.sel_s2       (sel_s2),
		.frame_end_s2 (frame_end_s2),
		.adv2         (adv2),
		.ready2       (ready2),
		.result       (result)
	);

endmodule

[tb/box_blur_3x3_stream_top_test.sv]
`timescale 1ns / 1ps
// box_blur_3x3_stream_top_test: self-checking bench for the 3x3 box blur stream
// drives pixel words and apb register writes, predicts every blurred word and checks it
// depends on bb3_pkg, bb3_in_if, bb3_out_if and box_blur_3x3_stream_top

module box_blur_3x3_stream_top_test;

	localparam int unsigned MAX_W      = 2048;
	localparam int unsigned MAX_H      = 2048;
	localparam int unsigned PIPE_WAIT  = 8;
	localparam int unsigned RAND_ITEMS = 610;
	localparam int          LIMIT      = 1500000;

	typedef struct packed {
		logic          action;
		bb3_pkg::rgb_t px;
	} pix_word_t;

	typedef struct packed {
		bb3_pkg::rgb_t px;
		logic          frame_end;
	} blur_word_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       psel;
	logic                       penable;
	logic                       pwrite;
	logic [bb3_pkg::APB_AW-1:0] paddr;
	logic [bb3_pkg::APB_DW-1:0] pwdata;
	logic [bb3_pkg::APB_DW-1:0] prdata;
	logic                       pready;

	bb3_in_if  pix_ch ();
	bb3_out_if res_ch ();

	box_blur_3x3_stream_top #(
		.MAX_WIDTH  (MAX_W),
		.MAX_HEIGHT (MAX_H)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pixel   (pix_ch),
		.result  (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	pix_word_t   pixel_queue[$];
	blur_word_t  blur_expected[$];
	int          err_count = 0;
	int          cycle_count = 0;
	int unsigned stream_items = 0;
	logic [11:0] stim_w = bb3_pkg::RST_WIDTH;
	logic [11:0] stim_h = bb3_pkg::RST_HEIGHT;

	// predictor state
	bb3_pkg::rgb_t top_row [MAX_W];
	bb3_pkg::rgb_t mid_row [MAX_W];
	bb3_pkg::rgb_t win [9];
	int unsigned   in_col, in_row, out_col, out_row;
	logic [11:0]   cfg_width, cfg_height;

	function automatic int unsigned clamp_dim(input logic [11:0] v, input int unsigned maxv);
		int unsigned d;
		d = v;
		if (d < 2) d = 2;
		if (d > maxv) d = maxv;
		return d;
	endfunction

	function automatic void restart_frame();
		in_col = 0;
		in_row = 0;
		out_col = 0;
		out_row = 0;
	endfunction

	// window rows: 0 two rows back, 1 previous row, 2 current; column 2 newest
	function automatic void shift_window(input bb3_pkg::rgb_t t, input bb3_pkg::rgb_t m,
			input bb3_pkg::rgb_t b);
		bb3_pkg::rgb_t v [3];
		int r;
		v[0] = t;
		v[1] = m;
		v[2] = b;
		for (r = 0; r < 3; r++) begin
			win[r*3] = win[r*3+1];
			win[r*3+1] = win[r*3+2];
			win[r*3+2] = v[r];
		end
	endfunction

	function automatic blur_word_t blur_window(input int lo, input int unsigned h,
			input int unsigned w);
		blur_word_t o;
		int r0, r1, r, c;
		int unsigned cnt, s_r, s_g, s_b;
		r0 = (out_row == 0) ? 1 : 0;
		r1 = (out_row + 1 >= h) ? 1 : 2;
		cnt = (r1 - r0 + 1) * (3 - lo);
		s_r = 0;
		s_g = 0;
		s_b = 0;
		for (r = r0; r <= r1; r++)
			for (c = lo; c <= 2; c++) begin
				s_r += win[r*3+c].red;
				s_g += win[r*3+c].green;
				s_b += win[r*3+c].blue;
			end
		o.px.red = 8'((s_r + cnt / 2) / cnt);
		o.px.green = 8'((s_g + cnt / 2) / cnt);
		o.px.blue = 8'((s_b + cnt / 2) / cnt);
		o.frame_end = (out_row + 1 == h) && (out_col + 1 == w);
		return o;
	endfunction

	function automatic bit blur_step(input pix_word_t word, output blur_word_t res);
		int unsigned   w, h, i, j;
		bit            drain, vld, got;
		bb3_pkg::rgb_t px, t, m;
		w = clamp_dim(cfg_width, MAX_W);
		h = clamp_dim(cfg_height, MAX_H);
		i = in_row;
		j = in_col;
		res = '0;
		got = 1'b0;
		// drain word inside the frame is dropped
		if (word.action && i < h)
			return 1'b0;
		drain = word.action || (i >= h);
		vld = (i >= 2) || (i == 1 && j >= 1);
		px = drain ? '0 : word.px;
		t = '0;
		m = '0;
		if (j < MAX_W) begin
			t = top_row[j];
			m = mid_row[j];
			if (!drain) begin
				top_row[j] = m;
				mid_row[j] = px;
			end
		end
		if (j == 0) begin
			// right edge of the previous row comes from the window as it stands
			if (vld) begin
				res = blur_window(1, h, w);
				got = 1'b1;
			end
			shift_window(t, m, px);
		end else begin
			shift_window(t, m, px);
			if (vld) begin
				res = blur_window((j >= 2) ? 0 : 1, h, w);
				got = 1'b1;
			end
		end
		if (got) begin
			if (res.frame_end) begin
				restart_frame();
				return 1'b1;
			end
			out_col++;
			if (out_col >= w) begin
				out_col = 0;
				out_row++;
			end
		end
		in_col++;
		if (in_col >= w) begin
			in_col = 0;
			in_row++;
		end
		return got;
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			err_count++;
		end
	endtask

	// monitor: checks result words, predicts from taken pixel words and register writes
	pix_word_t  mon_in;
	blur_word_t mon_res, mon_want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_width = bb3_pkg::RST_WIDTH;
			cfg_height = bb3_pkg::RST_HEIGHT;
			restart_frame();
			foreach (win[k])
				win[k] = '0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (blur_expected.size() == 0) begin
					$error("result word with none expected: rgb %h frame_end %0d",
						{res_ch.out_red, res_ch.out_green, res_ch.out_blue},
						res_ch.frame_end);
					err_count++;
				end else begin
					mon_want = blur_expected.pop_front();
					check_field("out_red", mon_want.px.red, res_ch.out_red);
					check_field("out_green", mon_want.px.green, res_ch.out_green);
					check_field("out_blue", mon_want.px.blue, res_ch.out_blue);
					check_field("frame_end", mon_want.frame_end, res_ch.frame_end);
				end
			end
			if (pix_ch.valid && pix_ch.ready) begin
				mon_in.action = pix_ch.action;
				mon_in.px = {pix_ch.in_red, pix_ch.in_green, pix_ch.in_blue};
				if (blur_step(mon_in, mon_res))
					blur_expected.push_back(mon_res);
			end
			if (psel && penable && pwrite && pready) begin
				if (bb3_pkg::reg_idx_t'(paddr[2]) == bb3_pkg::REG_WIDTH)
					cfg_width = pwdata[11:0];
				else
					cfg_height = pwdata[11:0];
				restart_frame();
			end
		end
	end

	// driver: bursts of words with random gaps between them
	int unsigned burst_left, gap_left;
	pix_word_t   drv_word;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_ch.valid <= 1'b0;
			pix_ch.action <= 1'b0;
			pix_ch.in_red <= '0;
			pix_ch.in_green <= '0;
			pix_ch.in_blue <= '0;
			burst_left <= 1;
			gap_left <= 0;
		end else if (!pix_ch.valid || pix_ch.ready) begin
			if (gap_left != 0 || pixel_queue.size() == 0) begin
				pix_ch.valid <= 1'b0;
				if (gap_left != 0)
					gap_left <= gap_left - 1;
			end else begin
				drv_word = pixel_queue.pop_front();
				pix_ch.valid <= 1'b1;
				pix_ch.action <= drv_word.action;
				pix_ch.in_red <= drv_word.px.red;
				pix_ch.in_green <= drv_word.px.green;
				pix_ch.in_blue <= drv_word.px.blue;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 48);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	// receiver stall pattern
	int unsigned hold_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			hold_left <= 0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (res_ch.ready) begin
			res_ch.ready <= 1'b0;
			hold_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(5, 16) :
				$urandom_range(0, 2);
		end else begin
			res_ch.ready <= 1'b1;
			hold_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) :
				$urandom_range(1, 40);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic bb3_pkg::rgb_t rand_pixel();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return 24'($urandom());
		endcase
	endfunction

	task automatic push_word(input logic action, input bb3_pkg::rgb_t px);
		pix_word_t word;
		word.action = action;
		word.px = px;
		pixel_queue.push_back(word);
	endtask

	task automatic push_frame(input int unsigned n_pix, input int unsigned n_tail,
			input bit noisy);
		int unsigned k;
		for (k = 0; k < n_pix; k++) begin
			if (noisy && $urandom_range(0, 15) == 0)
				push_word(1'b1, rand_pixel());
			push_word(1'b0, rand_pixel());
		end
		for (k = 0; k < n_tail; k++)
			push_word(1'(($urandom_range(0, 2) != 0)), rand_pixel());
		stream_items += n_pix + n_tail;
	endtask

	task automatic wait_idle(input int unsigned extra);
		@(negedge clk);
		while (pixel_queue.size() != 0 || pix_ch.valid || blur_expected.size() != 0)
			@(negedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_reg(input bb3_pkg::reg_idx_t idx, input logic [11:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {20'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == bb3_pkg::REG_WIDTH)
			stim_w = val;
		else
			stim_h = val;
		@(negedge clk);
	endtask

	task automatic set_size(input logic [11:0] w, input logic [11:0] h);
		wait_idle(PIPE_WAIT);
		write_reg(bb3_pkg::REG_WIDTH, w);
		write_reg(bb3_pkg::REG_HEIGHT, h);
	endtask

	initial begin
		int unsigned start_items, frames, f, w, h, mode;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset size 640 x 480: a few words, no result yet, cut short by the next write
		push_frame(8, 0, 1'b1);

		// smallest frame, extreme channel values, drains early and late
		set_size(12'd2, 12'd2);
		push_word(1'b1, 24'h123456);
		push_word(1'b0, 24'hff00ff);
		push_word(1'b1, 24'hffffff);
		push_word(1'b0, 24'h00ff00);
		push_word(1'b0, 24'hffffff);
		push_word(1'b0, 24'h000000);
		push_word(1'b0, 24'hffffff);
		push_word(1'b1, 24'h000000);
		push_word(1'b1, 24'hffffff);
		push_word(1'b1, 24'h000000);

		// sizes below two act as two
		set_size(12'd0, 12'd1);
		push_word(1'b0, 24'hffffff);
		push_word(1'b0, 24'hffffff);
		push_word(1'b0, 24'hffffff);
		push_word(1'b0, 24'h000000);
		push_frame(0, 3, 1'b0);

		// 3 x 3 with a pause mid frame until all results are out
		set_size(12'd3, 12'd3);
		push_frame(4, 0, 1'b0);
		wait_idle(0);
		push_frame(5, 4, 1'b0);

		start_items = stream_items;
		while (stream_items - start_items < RAND_ITEMS) begin
			wait_idle(PIPE_WAIT);
			mode = $urandom_range(0, 3);
			if (mode != 1) begin
				case ($urandom_range(0, 9))
					0: write_reg(bb3_pkg::REG_WIDTH, 12'($urandom_range(0, 1)));
					1: write_reg(bb3_pkg::REG_WIDTH, 12'($urandom_range(13, 40)));
					default: write_reg(bb3_pkg::REG_WIDTH, 12'($urandom_range(2, 12)));
				endcase
			end
			if (mode != 0) begin
				if ($urandom_range(0, 9) == 0)
					write_reg(bb3_pkg::REG_HEIGHT, 12'($urandom_range(0, 1)));
				else
					write_reg(bb3_pkg::REG_HEIGHT, 12'($urandom_range(2, 8)));
			end
			w = clamp_dim(stim_w, MAX_W);
			h = clamp_dim(stim_h, MAX_H);
			frames = $urandom_range(1, 3);
			for (f = 0; f < frames; f++) begin
				if ($urandom_range(0, 7) == 0) begin
					// broken frame, restarted by the next register write
					if ($urandom_range(0, 1) == 0)
						push_frame($urandom_range(1, w * h - 1), 0, 1'b1);
					else
						push_frame(w * h, $urandom_range(0, w), 1'b1);
					break;
				end
				push_frame(w * h, w + 1, 1'b1);
				if ($urandom_range(0, 5) == 0)
					wait_idle(0);
			end
		end

		wait_idle(PIPE_WAIT);
		if (err_count == 0 && blur_expected.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

[box_blur_3x3_stream_top.f]
rtl/bb3_pkg.sv
rtl/bb3_stream_if.sv
rtl/bb3_ram.sv
rtl/bb3_cfg.sv
rtl/bb3_ctl.sv
rtl/bb3_window.sv
rtl/bb3_div.sv
rtl/box_blur_3x3_stream_top.sv
tb/box_blur_3x3_stream_top_test.sv
